// ===== rtl/core/ptb_pkg.sv =====
// Shared types and constants of the primitive tile binning block.
package ptb_pkg;

    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int TILE_W     = 13;
    localparam int BOX_W      = 14;
    localparam int VP_POS_W   = 13;
    localparam int VP_DIM_W   = 14;
    localparam int TSIZE_W    = 9;
    localparam int LINE_W_W   = 16;

    localparam logic [VP_DIM_W-1:0] VP_DIM_MAX   = 14'd8192;
    localparam logic [LINE_W_W-1:0] LINE_W_MIN   = 16'd128;

    typedef enum logic [1:0] {
        KIND_POINT = 2'd0,
        KIND_LINE  = 2'd1,
        KIND_TRI   = 2'd2,
        KIND_BAD   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_BINNED = 2'd0,
        ST_CULLED = 2'd1,
        ST_ERROR  = 2'd2
    } t_status;

    localparam logic [CFG_IDX_W-1:0] REG_VP_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VP_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VP_W   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VP_H   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_W = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_H = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_W = 3'd6;

    // Configuration as seen by the datapath: dimensions already capped,
    // tile sizes already forced non-zero.
    typedef struct packed {
        logic [VP_POS_W-1:0] vp_x;
        logic [VP_POS_W-1:0] vp_y;
        logic [VP_DIM_W-1:0] vp_w;
        logic [VP_DIM_W-1:0] vp_h;
        logic [TSIZE_W-1:0]  tile_w;
        logic [TSIZE_W-1:0]  tile_h;
        logic [LINE_W_W-1:0] line_w;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic               err;
        logic [COORD_W-1:0] v0_x;
        logic [COORD_W-1:0] v0_y;
        logic [COORD_W-1:0] v0_w;
        logic [COORD_W-1:0] v1_x;
        logic [COORD_W-1:0] v1_y;
        logic [COORD_W-1:0] v1_w;
        logic [COORD_W-1:0] v2_x;
        logic [COORD_W-1:0] v2_y;
        logic [COORD_W-1:0] v2_w;
    } t_item;

endpackage

// ===== rtl/core/ptb_if.sv =====
// Handshake interfaces for the primitive and result channels.
interface ptb_prim_if;
    logic        valid;
    logic        ready;
    logic [1:0]  prim_kind;
    logic signed [31:0] v0_x;
    logic signed [31:0] v0_y;
    logic signed [31:0] v0_w;
    logic signed [31:0] v1_x;
    logic signed [31:0] v1_y;
    logic signed [31:0] v1_w;
    logic signed [31:0] v2_x;
    logic signed [31:0] v2_y;
    logic signed [31:0] v2_w;

    modport source (
        output valid, prim_kind, v0_x, v0_y, v0_w, v1_x, v1_y, v1_w, v2_x, v2_y, v2_w,
        input  ready
    );
    modport sink (
        input  valid, prim_kind, v0_x, v0_y, v0_w, v1_x, v1_y, v1_w, v2_x, v2_y, v2_w,
        output ready
    );
endinterface

interface ptb_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [12:0] first_tile_col;
    logic [12:0] last_tile_col;
    logic [12:0] first_tile_row;
    logic [12:0] last_tile_row;
    logic [13:0] box_min_x;
    logic [13:0] box_max_x;
    logic [13:0] box_min_y;
    logic [13:0] box_max_y;

    modport source (
        output valid, status, first_tile_col, last_tile_col, first_tile_row,
               last_tile_row, box_min_x, box_max_x, box_min_y, box_max_y,
        input  ready
    );
    modport sink (
        input  valid, status, first_tile_col, last_tile_col, first_tile_row,
               last_tile_row, box_min_x, box_max_x, box_min_y, box_max_y,
        output ready
    );
endinterface

// ===== rtl/core/ptb_front.sv =====
// Front end: accepts primitives, flags bad kinds and w values, and queues them.
module ptb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ptb_prim_if.sink        i_prim,
    input  logic            i_pop,
    output ptb_pkg::t_item  o_item,
    output logic            o_avail
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    ptb_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_cnt;
    ptb_pkg::t_item n_item;
    logic           push, pop;
    logic           w0_bad, w1_bad, w2_bad;
    ptb_pkg::t_kind kind;

    assign kind   = ptb_pkg::t_kind'(i_prim.prim_kind);
    assign w0_bad = i_prim.v0_w[31] || (i_prim.v0_w == '0);
    assign w1_bad = i_prim.v1_w[31] || (i_prim.v1_w == '0);
    assign w2_bad = i_prim.v2_w[31] || (i_prim.v2_w == '0);

    always_comb begin
        n_item.kind = kind;
        n_item.v0_x = i_prim.v0_x;
        n_item.v0_y = i_prim.v0_y;
        n_item.v0_w = i_prim.v0_w;
        n_item.v1_x = i_prim.v1_x;
        n_item.v1_y = i_prim.v1_y;
        n_item.v1_w = i_prim.v1_w;
        n_item.v2_x = i_prim.v2_x;
        n_item.v2_y = i_prim.v2_y;
        n_item.v2_w = i_prim.v2_w;
        // Only the vertices that the kind uses are checked.
        case (kind)
            ptb_pkg::KIND_POINT: n_item.err = w0_bad;
            ptb_pkg::KIND_LINE:  n_item.err = w0_bad || w1_bad;
            ptb_pkg::KIND_TRI:   n_item.err = w0_bad || w1_bad || w2_bad;
            default:             n_item.err = 1'b1;
        endcase
    end

    assign i_prim.ready = (r_cnt != (AW+1)'(DEPTH));
    assign push         = i_prim.valid && i_prim.ready;
    assign o_avail      = (r_cnt != '0);
    assign pop          = i_pop && o_avail;
    assign o_item       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/ptb_ndc_div.sv =====
// Pipelined clip-to-NDC divider: floor(num * 2^FRAC / den), saturated, one bit per stage.
module ptb_ndc_div #(
    parameter int FRAC = 16
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [31:0]            i_num,
    input  logic [31:0]            i_den,
    output logic signed [FRAC+16:0] o_ndc
);

    localparam int QW = FRAC + 16;
    localparam int NW = FRAC + 17;
    localparam logic [QW:0] LIM = (QW+1)'(1) << (FRAC + 15);

    logic [31:0]    r_rem [QW+1];
    logic [QW-1:0]  r_low [QW+1];
    logic [QW-1:0]  r_quo [QW+1];
    logic [31:0]    r_den [QW+1];
    logic           r_neg [QW+1];
    logic           r_ovf [QW+1];
    logic [31:0]    n_rem [QW+1];
    logic [QW-1:0]  n_quo [QW+1];
    logic signed [NW-1:0] r_ndc;

    logic           neg;
    logic [31:0]    ax;
    logic [QW:0]    mag;
    logic [QW:0]    mag_sat;

    assign neg = i_num[31];
    assign ax  = neg ? (32'd0 - i_num) : i_num;

    always_comb begin
        n_rem[0] = {16'd0, ax[31:16]};
        n_quo[0] = '0;
        for (int k = 1; k <= QW; k++) begin
            logic [32:0] cand;
            logic        ge;
            cand = {r_rem[k-1], r_low[k-1][QW-1]};
            ge   = (cand >= {1'b0, r_den[k-1]});
            n_rem[k] = ge ? 32'(cand - {1'b0, r_den[k-1]}) : cand[31:0];
            n_quo[k] = {r_quo[k-1][QW-2:0], ge};
        end
    end

    // Negative numerators round towards minus infinity: add one on a remainder.
    always_comb begin
        mag = {1'b0, r_quo[QW]};
        if (r_neg[QW] && (r_rem[QW] != '0)) begin
            mag = mag + 1'b1;
        end
        mag_sat = (r_ovf[QW] || (mag > LIM)) ? LIM : mag;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_low[0] <= {ax[15:0], {FRAC{1'b0}}};
            r_quo[0] <= n_quo[0];
            r_den[0] <= i_den;
            r_neg[0] <= neg;
            r_ovf[0] <= ({16'd0, ax[31:16]} >= i_den);
            for (int k = 1; k <= QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= {r_low[k-1][QW-2:0], 1'b0};
                r_quo[k] <= n_quo[k];
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
            r_ndc <= r_neg[QW] ? $signed((QW+1)'(0) - mag_sat) : $signed(mag_sat);
        end
    end

    assign o_ndc = r_ndc;

endmodule

// ===== rtl/core/ptb_tile_div.sv =====
// Pipelined restoring divider for the tile index: one quotient bit per stage.
module ptb_tile_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ptb_pkg::TILE_W-1:0]   i_num,
    input  logic [ptb_pkg::TSIZE_W-1:0]  i_den,
    output logic [ptb_pkg::TILE_W-1:0]   o_quo
);

    localparam int NB = ptb_pkg::TILE_W;
    localparam int DB = ptb_pkg::TSIZE_W;

    logic [DB-1:0] r_rem [NB];
    logic [NB-1:0] r_num [NB];
    logic [NB-1:0] r_quo [NB];
    logic [DB-1:0] n_rem [NB];
    logic [NB-1:0] n_num [NB];
    logic [NB-1:0] n_quo [NB];

    // The divisor is configuration; users hold it still with items in flight.
    always_comb begin
        for (int k = 0; k < NB; k++) begin
            logic [DB-1:0] rem_in;
            logic [NB-1:0] num_in;
            logic [NB-1:0] quo_in;
            logic [DB:0]   cand;
            logic          ge;
            rem_in = (k == 0) ? '0 : r_rem[(k == 0) ? 0 : k-1];
            num_in = (k == 0) ? i_num : r_num[(k == 0) ? 0 : k-1];
            quo_in = (k == 0) ? '0 : r_quo[(k == 0) ? 0 : k-1];
            cand   = {rem_in, num_in[NB-1]};
            ge     = (cand >= {1'b0, i_den});
            n_rem[k] = ge ? DB'(cand - {1'b0, i_den}) : cand[DB-1:0];
            n_num[k] = {num_in[NB-2:0], 1'b0};
            n_quo[k] = {quo_in[NB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NB; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[NB-1];

endmodule

// ===== rtl/core/ptb_back.sv =====
// Back end: projection, viewport mapping, bounding box, clipping and tile range.
module ptb_back #(
    parameter int FRAC = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptb_pkg::t_cfg   i_cfg,
    input  ptb_pkg::t_item  i_item,
    input  logic            i_avail,
    output logic            o_pop,
    ptb_res_if.source       o_res
);

    localparam int NW  = FRAC + 17;
    localparam int D   = FRAC + 18;
    localparam int SBN = D + 3;
    localparam int PW  = FRAC + 33;
    localparam int PXW = PW - FRAC;
    localparam int NB  = ptb_pkg::TILE_W;
    localparam int BW  = ptb_pkg::BOX_W;

    localparam logic signed [FRAC+17:0] ONE_N  = (FRAC+18)'(1) << FRAC;
    localparam logic signed [PW-1:0]    ONE_M1 = (PW'(1) << FRAC) - PW'(1);
    localparam logic signed [PXW-1:0]   PX_ONE = PXW'(1);

    typedef struct packed {
        ptb_pkg::t_kind kind;
        logic           err;
    } t_side;

    typedef struct packed {
        ptb_pkg::t_status status;
        logic [BW-1:0]    x0;
        logic [BW-1:0]    x1;
        logic [BW-1:0]    y0;
        logic [BW-1:0]    y1;
    } t_tside;

    logic en;

    t_side  r_sb [SBN];
    t_tside r_ts [NB];
    logic   r_sb_vld [SBN];
    logic   r_ts_vld [NB];
    logic   r_c_vld;

    logic signed [NW-1:0] ndc_x [3];
    logic signed [NW-1:0] ndc_y [3];
    logic [31:0]          vx_in [3];
    logic [31:0]          vy_in [3];
    logic [31:0]          vw_in [3];

    logic signed [PW-1:0] r_px [3];
    logic signed [PW-1:0] r_py [3];
    logic signed [PW-1:0] n_px [3];
    logic signed [PW-1:0] n_py [3];
    logic signed [PW-1:0] r_sx [3];
    logic signed [PW-1:0] r_sy [3];
    logic signed [PW-1:0] r_mnx, r_mxx, r_mny, r_mxy;
    logic signed [PW-1:0] n_mnx, n_mxx, n_mny, n_mxy;

    t_tside               n_c;
    t_tside               r_c;
    logic [NB-1:0]        r_off [4];
    logic [NB-1:0]        n_off [4];
    logic [NB-1:0]        quo   [4];

    logic signed [14:0]   vw_s, vh_s;
    logic signed [PW-1:0] vpx_f, vpy_f;

    logic                 r_out_valid;
    ptb_pkg::t_status     r_out_status;
    logic [NB-1:0]        r_out_tile [4];
    logic [BW-1:0]        r_out_box  [4];

    assign en    = !r_out_valid || o_res.ready;
    assign o_pop = en;

    assign vx_in[0] = i_item.v0_x;
    assign vy_in[0] = i_item.v0_y;
    assign vw_in[0] = i_item.v0_w;
    assign vx_in[1] = i_item.v1_x;
    assign vy_in[1] = i_item.v1_y;
    assign vw_in[1] = i_item.v1_w;
    assign vx_in[2] = i_item.v2_x;
    assign vy_in[2] = i_item.v2_y;
    assign vw_in[2] = i_item.v2_w;

    for (genvar v = 0; v < 3; v++) begin : g_vtx
        ptb_ndc_div #(.FRAC(FRAC)) u_div_x (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (vx_in[v]),
            .i_den (vw_in[v]),
            .o_ndc (ndc_x[v])
        );
        ptb_ndc_div #(.FRAC(FRAC)) u_div_y (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (vy_in[v]),
            .i_den (vw_in[v]),
            .o_ndc (ndc_y[v])
        );
    end

    assign vw_s  = $signed({1'b0, i_cfg.vp_w});
    assign vh_s  = $signed({1'b0, i_cfg.vp_h});
    assign vpx_f = $signed({{(PW-13-FRAC){1'b0}}, i_cfg.vp_x, {FRAC{1'b0}}});
    assign vpy_f = $signed({{(PW-13-FRAC){1'b0}}, i_cfg.vp_y, {FRAC{1'b0}}});

    // Viewport scale; y is flipped so that the top of clip space is row zero.
    always_comb begin
        for (int v = 0; v < 3; v++) begin
            logic signed [FRAC+17:0] nxo, nyo;
            nxo = $signed({ndc_x[v][NW-1], ndc_x[v]}) + ONE_N;
            nyo = ONE_N - $signed({ndc_y[v][NW-1], ndc_y[v]});
            n_px[v] = PW'(vw_s) * PW'(nxo);
            n_py[v] = PW'(vh_s) * PW'(nyo);
        end
    end

    // Bounding box over the vertices that the kind uses, widened for lines.
    always_comb begin
        logic                 use1, use2;
        logic [15:0]          lw_m;
        logic [FRAC+15:0]     hw_full;
        logic signed [PW-1:0] hw;
        use1 = (r_sb[D+1].kind != ptb_pkg::KIND_POINT);
        use2 = (r_sb[D+1].kind == ptb_pkg::KIND_TRI);
        lw_m = (i_cfg.line_w < ptb_pkg::LINE_W_MIN) ? ptb_pkg::LINE_W_MIN : i_cfg.line_w;
        hw_full = {lw_m, {FRAC{1'b0}}} >> 9;
        hw = $signed({{(PW-16-FRAC){1'b0}}, hw_full});
        n_mnx = r_sx[0];
        n_mxx = r_sx[0];
        n_mny = r_sy[0];
        n_mxy = r_sy[0];
        if (use1) begin
            if (r_sx[1] < n_mnx) n_mnx = r_sx[1];
            if (r_sx[1] > n_mxx) n_mxx = r_sx[1];
            if (r_sy[1] < n_mny) n_mny = r_sy[1];
            if (r_sy[1] > n_mxy) n_mxy = r_sy[1];
        end
        if (use2) begin
            if (r_sx[2] < n_mnx) n_mnx = r_sx[2];
            if (r_sx[2] > n_mxx) n_mxx = r_sx[2];
            if (r_sy[2] < n_mny) n_mny = r_sy[2];
            if (r_sy[2] > n_mxy) n_mxy = r_sy[2];
        end
        if (r_sb[D+1].kind == ptb_pkg::KIND_LINE) begin
            n_mnx = n_mnx - hw;
            n_mny = n_mny - hw;
            n_mxx = n_mxx + hw;
            n_mxy = n_mxy + hw;
        end
    end

    // Pixel rounding, clipping to the viewport and the cull decision.
    always_comb begin
        logic signed [PXW-1:0] bx0, bx1, by0, by1;
        logic signed [PXW-1:0] lo_x, lo_y, hi_x, hi_y;
        logic signed [PXW-1:0] cx0, cx1, cy0, cy1;
        logic signed [PW-1:0]  tx, ty;
        logic                  cull;
        bx0 = $signed(r_mnx[PW-1:FRAC]);
        by0 = $signed(r_mny[PW-1:FRAC]);
        tx  = r_mxx + ONE_M1;
        ty  = r_mxy + ONE_M1;
        if (r_sb[D+2].kind == ptb_pkg::KIND_POINT) begin
            bx1 = bx0;
            by1 = by0;
        end else begin
            bx1 = $signed(tx[PW-1:FRAC]);
            by1 = $signed(ty[PW-1:FRAC]);
        end
        lo_x = $signed({{(PXW-13){1'b0}}, i_cfg.vp_x});
        lo_y = $signed({{(PXW-13){1'b0}}, i_cfg.vp_y});
        hi_x = lo_x + $signed({{(PXW-14){1'b0}}, i_cfg.vp_w}) - PX_ONE;
        hi_y = lo_y + $signed({{(PXW-14){1'b0}}, i_cfg.vp_h}) - PX_ONE;
        cx0 = (bx0 < lo_x) ? lo_x : bx0;
        cy0 = (by0 < lo_y) ? lo_y : by0;
        cx1 = (bx1 > hi_x) ? hi_x : bx1;
        cy1 = (by1 > hi_y) ? hi_y : by1;
        cull = (cx0 > cx1) || (cy0 > cy1);
        if (r_sb[D+2].err) begin
            n_c.status = ptb_pkg::ST_ERROR;
        end else if (cull) begin
            n_c.status = ptb_pkg::ST_CULLED;
        end else begin
            n_c.status = ptb_pkg::ST_BINNED;
        end
        n_c.x0 = cx0[BW-1:0];
        n_c.x1 = cx1[BW-1:0];
        n_c.y0 = cy0[BW-1:0];
        n_c.y1 = cy1[BW-1:0];
        n_off[0] = NB'(cx0 - lo_x);
        n_off[1] = NB'(cx1 - lo_x);
        n_off[2] = NB'(cy0 - lo_y);
        n_off[3] = NB'(cy1 - lo_y);
    end

    for (genvar t = 0; t < 4; t++) begin : g_tile
        ptb_tile_div u_tdiv (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_off[t]),
            .i_den ((t < 2) ? i_cfg.tile_w : i_cfg.tile_h),
            .o_quo (quo[t])
        );
    end

    // Datapath registers; only the valid flags below carry a reset.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int v = 0; v < 3; v++) begin
                r_px[v] <= n_px[v];
                r_py[v] <= n_py[v];
                r_sx[v] <= vpx_f + (r_px[v] >>> 1);
                r_sy[v] <= vpy_f + (r_py[v] >>> 1);
            end
            r_mnx <= n_mnx;
            r_mxx <= n_mxx;
            r_mny <= n_mny;
            r_mxy <= n_mxy;
            for (int t = 0; t < 4; t++) begin
                r_off[t] <= n_off[t];
            end
            r_sb[0].kind <= i_item.kind;
            r_sb[0].err  <= i_item.err;
            for (int k = 1; k < SBN; k++) begin
                r_sb[k].kind <= r_sb[k-1].kind;
                r_sb[k].err  <= r_sb[k-1].err;
            end
            r_c.status <= n_c.status;
            r_c.x0     <= n_c.x0;
            r_c.x1     <= n_c.x1;
            r_c.y0     <= n_c.y0;
            r_c.y1     <= n_c.y1;
            r_ts[0].status <= r_c.status;
            r_ts[0].x0     <= r_c.x0;
            r_ts[0].x1     <= r_c.x1;
            r_ts[0].y0     <= r_c.y0;
            r_ts[0].y1     <= r_c.y1;
            for (int k = 1; k < NB; k++) begin
                r_ts[k].status <= r_ts[k-1].status;
                r_ts[k].x0     <= r_ts[k-1].x0;
                r_ts[k].x1     <= r_ts[k-1].x1;
                r_ts[k].y0     <= r_ts[k-1].y0;
                r_ts[k].y1     <= r_ts[k-1].y1;
            end
            r_out_status <= r_ts[NB-1].status;
            if (r_ts[NB-1].status == ptb_pkg::ST_BINNED) begin
                for (int t = 0; t < 4; t++) begin
                    r_out_tile[t] <= quo[t];
                end
                r_out_box[0] <= r_ts[NB-1].x0;
                r_out_box[1] <= r_ts[NB-1].x1;
                r_out_box[2] <= r_ts[NB-1].y0;
                r_out_box[3] <= r_ts[NB-1].y1;
            end else begin
                for (int t = 0; t < 4; t++) begin
                    r_out_tile[t] <= '0;
                    r_out_box[t]  <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SBN; k++) begin
                r_sb_vld[k] <= 1'b0;
            end
            r_c_vld <= 1'b0;
            for (int k = 0; k < NB; k++) begin
                r_ts_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sb_vld[0] <= i_avail;
            for (int k = 1; k < SBN; k++) begin
                r_sb_vld[k] <= r_sb_vld[k-1];
            end
            r_c_vld     <= r_sb_vld[D+2];
            r_ts_vld[0] <= r_c_vld;
            for (int k = 1; k < NB; k++) begin
                r_ts_vld[k] <= r_ts_vld[k-1];
            end
            r_out_valid <= r_ts_vld[NB-1];
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out_status;
    assign o_res.first_tile_col = r_out_tile[0];
    assign o_res.last_tile_col  = r_out_tile[1];
    assign o_res.first_tile_row = r_out_tile[2];
    assign o_res.last_tile_row  = r_out_tile[3];
    assign o_res.box_min_x      = r_out_box[0];
    assign o_res.box_max_x      = r_out_box[1];
    assign o_res.box_min_y      = r_out_box[2];
    assign o_res.box_max_y      = r_out_box[3];

endmodule

// ===== rtl/core/primitive_tile_binning.sv =====
// Primitive tile binning: bounding box and tile range of points, lines and triangles.
//
// Primitives arrive on i_prim (valid/ready); each transfer carries a kind and three
// clip-space vertices in signed Q16.16. Each primitive gives exactly one result on
// o_res: a status (binned, culled, or error for a bad kind or a w of zero or less),
// the clipped pixel box and the inclusive tile range. Results leave in arrival order.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data; the
// user must write them only while no primitive is in flight; the block does not
// enforce this. Results pass through the bit-per-stage perspective dividers and the
// bit-per-stage tile dividers. One primitive is taken every cycle unless the receiver
// stalls o_res.
// A four-entry queue sits between the front end and the datapath. When the receiver
// holds ready low on a valid result the whole datapath freezes, the queue fills, and
// i_prim.ready falls only once the queue is full; no transfer is lost.
// Reset empties the queue and pipeline and restores the register defaults: empty
// viewport (everything culls), 16 by 16 pixel tiles, line width one pixel.
module primitive_tile_binning #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ptb_prim_if.sink                         i_prim,
    ptb_res_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [ptb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ptb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [ptb_pkg::VP_POS_W-1:0] r_vp_x, r_vp_y;
    logic [ptb_pkg::VP_DIM_W-1:0] r_vp_w, r_vp_h;
    logic [ptb_pkg::TSIZE_W-1:0]  r_tile_w, r_tile_h;
    logic [ptb_pkg::LINE_W_W-1:0] r_line_w;

    ptb_pkg::t_cfg  cfg;
    ptb_pkg::t_item item;
    logic           avail;
    logic           pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_x   <= '0;
            r_vp_y   <= '0;
            r_vp_w   <= '0;
            r_vp_h   <= '0;
            r_tile_w <= 9'd16;
            r_tile_h <= 9'd16;
            r_line_w <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ptb_pkg::REG_VP_X:   r_vp_x   <= i_cfg_data[ptb_pkg::VP_POS_W-1:0];
                ptb_pkg::REG_VP_Y:   r_vp_y   <= i_cfg_data[ptb_pkg::VP_POS_W-1:0];
                ptb_pkg::REG_VP_W:   r_vp_w   <= i_cfg_data[ptb_pkg::VP_DIM_W-1:0];
                ptb_pkg::REG_VP_H:   r_vp_h   <= i_cfg_data[ptb_pkg::VP_DIM_W-1:0];
                ptb_pkg::REG_TILE_W: r_tile_w <= i_cfg_data[ptb_pkg::TSIZE_W-1:0];
                ptb_pkg::REG_TILE_H: r_tile_h <= i_cfg_data[ptb_pkg::TSIZE_W-1:0];
                ptb_pkg::REG_LINE_W: r_line_w <= i_cfg_data[ptb_pkg::LINE_W_W-1:0];
                default: ;
            endcase
        end
    end

    // Oversized viewports act as 8192 pixels, and a zero tile size as one pixel.
    always_comb begin
        cfg.vp_x   = r_vp_x;
        cfg.vp_y   = r_vp_y;
        cfg.vp_w   = (r_vp_w > ptb_pkg::VP_DIM_MAX) ? ptb_pkg::VP_DIM_MAX : r_vp_w;
        cfg.vp_h   = (r_vp_h > ptb_pkg::VP_DIM_MAX) ? ptb_pkg::VP_DIM_MAX : r_vp_h;
        cfg.tile_w = (r_tile_w == '0) ? 9'd1 : r_tile_w;
        cfg.tile_h = (r_tile_h == '0) ? 9'd1 : r_tile_h;
        cfg.line_w = r_line_w;
    end

    ptb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prim  (i_prim),
        .i_pop   (pop),
        .o_item  (item),
        .o_avail (avail)
    );

    ptb_back #(.FRAC(COORD_FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_item  (item),
        .i_avail (avail),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
